// File: rtl/byte_level_token_text_decoder_unit_defines.svh
// Assertion macros used by the checker file of the token text decoder.
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_UNIT_DEFINES_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BLTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bltd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bltd assertion failed");

`endif

// File: rtl/bltd_pkg.sv
`timescale 1ns / 1ps
package bltd_pkg;

   // One input item: a UTF-8 byte of the token text and its end mark
   typedef struct packed {
      logic [7:0] in_byte;
      logic       token_last;
   } req_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       token_end;
   } rsp_type;

   localparam int unsigned CP_W = 21;

   // Lead byte tags
   localparam logic [2:0] LEAD2_TAG = 3'h6;
   localparam logic [3:0] LEAD3_TAG = 4'hE;
   localparam logic [4:0] LEAD4_TAG = 5'h1E;

   // UTF-8 re-encoding prefixes
   localparam logic [7:0] PFX_CONT  = 8'h80;
   localparam logic [7:0] PFX_LEAD2 = 8'hC0;
   localparam logic [7:0] PFX_LEAD3 = 8'hE0;
   localparam logic [7:0] PFX_LEAD4 = 8'hF0;

   // Code point boundaries
   localparam logic [CP_W-1:0] CP_ASCII_END = 21'h80;
   localparam logic [CP_W-1:0] CP_TWO_END   = 21'h800;
   localparam logic [CP_W-1:0] CP_THREE_END = 21'h10000;
   localparam logic [CP_W-1:0] CP_PRINT_LO  = 21'h21;
   localparam logic [CP_W-1:0] CP_PRINT_HI  = 21'h7E;
   localparam logic [CP_W-1:0] CP_LAT_LO    = 21'hA1;
   localparam logic [CP_W-1:0] CP_LAT_MID   = 21'hAC;
   localparam logic [CP_W-1:0] CP_LAT_HI_LO = 21'hAE;
   localparam logic [CP_W-1:0] CP_LAT_HI    = 21'hFF;
   localparam logic [CP_W-1:0] CP_SHIFT_LO  = 21'h100;
   localparam logic [CP_W-1:0] CP_SHIFT_HI  = 21'h143;

   // Inverse table for the shifted range (offset from 256)
   localparam logic [7:0] SHIFT_CTRL_END = 8'd33;
   localparam logic [7:0] SHIFT_HIGH_END = 8'd67;
   localparam logic [7:0] SHIFT_HIGH_ADD = 8'h5E;
   localparam logic [7:0] SHIFT_SOFT_HY  = 8'hAD;

endpackage

// File: rtl/byte_level_token_text_decoder_unit.sv
`timescale 1ns / 1ps
// Byte-level token text decoder.
// req channel: one UTF-8 byte of token text per item, with token_last on the final byte.
// rsp channel: bytes recovered from the code points, one per item (unmapped ones re-encoded
//   as UTF-8); run_last marks the last result of an input byte, token_end the last result
//   of the token. A token end that yields no data gives a single item with has_byte low.
// Both channels: item moves on a rising edge with valid high and stall low.
// Path: an accepted byte is captured in the input register, then decoded into the result
//   register, whose contents drive rsp.
// Throughput: with rsp_stall low, one input byte per cycle while each byte gives at most
//   one result. A code point that re-encodes to n bytes holds the result register until
//   the rsp port has drained all n, one item per cycle; bytes giving no result never hold it.
// The input register decouples req from rsp: one byte is taken even while a result is
//   stalled, after that req_stall stays high until the result register frees.
// Reset (synchronous, active high) empties both registers and clears the partial code
//   point and the count of continuation bytes owed.
module byte_level_token_text_decoder_unit
   import bltd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic    in_full_ff, in_full_in;
   req_type in_data_ff;

   // Decode state
   logic [CP_W-1:0] code_accum_ff, code_accum_in;
   logic [1:0]      bytes_owed_ff, bytes_owed_in;

   // Result register: up to four bytes drained one per cycle while rsp is not stalled
   logic            run_valid_ff, run_valid_in;
   logic [3:0][7:0] run_bytes_ff, run_bytes_in;
   logic [1:0]      run_last_idx_ff, run_last_idx_in;
   logic [1:0]      run_idx_ff, run_idx_in;
   logic            run_has_ff, run_has_in;
   logic            run_tok_ff, run_tok_in;

   logic run_free, in_move, req_accept, run_pop;

   // Decode outputs
   logic            dec_any;
   logic [3:0][7:0] dec_bytes;
   logic [1:0]      dec_last_idx;
   logic            dec_has;

   // Handshake
   assign run_pop    = run_valid_ff && !rsp_stall;
   assign run_free   = !run_valid_ff || (run_pop && (run_idx_ff == run_last_idx_ff));
   assign in_move    = in_full_ff && run_free;
   assign req_stall  = in_full_ff && !run_free;
   assign req_accept = req_valid && !req_stall;
   assign in_full_in = req_accept || (in_full_ff && !in_move);

   // Code point assembly and inverse byte mapping
   always_comb begin
      logic [7:0]      b;
      logic            done;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] merged;
      logic [7:0]      k;
      logic            mapped;
      logic [7:0]      raw;

      b             = in_data_ff.in_byte;
      done          = 1'b0;
      cp            = '0;
      merged        = code_accum_ff;
      k             = cp[7:0];
      mapped        = 1'b0;
      raw           = 8'h00;
      code_accum_in = code_accum_ff;
      bytes_owed_in = bytes_owed_ff;

      if (bytes_owed_ff == 2'd0) begin
         if (!b[7]) begin
            cp   = {13'd0, b};
            done = 1'b1;
         end else if (b[7:5] == LEAD2_TAG) begin
            code_accum_in = {10'd0, b[4:0], 6'd0};
            bytes_owed_in = 2'd1;
         end else if (b[7:4] == LEAD3_TAG) begin
            code_accum_in = {5'd0, b[3:0], 12'd0};
            bytes_owed_in = 2'd2;
         end else if (b[7:3] == LEAD4_TAG) begin
            code_accum_in = {b[2:0], 18'd0};
            bytes_owed_in = 2'd3;
         end
      end else begin
         case (bytes_owed_ff)
            2'd1:    merged = code_accum_ff | {15'd0, b[5:0]};
            2'd2:    merged = code_accum_ff | {9'd0, b[5:0], 6'd0};
            2'd3:    merged = code_accum_ff | {3'd0, b[5:0], 12'd0};
            default: merged = code_accum_ff;
         endcase
         bytes_owed_in = bytes_owed_ff - 2'd1;
         if (bytes_owed_ff == 2'd1) begin
            cp            = merged;
            code_accum_in = '0;
            done          = 1'b1;
         end else begin
            code_accum_in = merged;
         end
      end

      if (in_data_ff.token_last) begin
         code_accum_in = '0;
         bytes_owed_in = 2'd0;
      end

      // Inverse table lookup
      k = cp[7:0];
      if ((cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) ||
          (cp >= CP_LAT_LO && cp <= CP_LAT_MID) ||
          (cp >= CP_LAT_HI_LO && cp <= CP_LAT_HI)) begin
         mapped = 1'b1;
         raw    = cp[7:0];
      end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
         mapped = 1'b1;
         if (k < SHIFT_CTRL_END) begin
            raw = k;
         end else if (k < SHIFT_HIGH_END) begin
            raw = k + SHIFT_HIGH_ADD;
         end else begin
            raw = SHIFT_SOFT_HY;
         end
      end

      // Byte run for the finished code point
      dec_bytes    = '0;
      dec_last_idx = 2'd0;
      if (mapped) begin
         dec_bytes[0] = raw;
      end else if (cp < CP_ASCII_END) begin
         dec_bytes[0] = cp[7:0];
      end else if (cp < CP_TWO_END) begin
         dec_bytes[0] = PFX_LEAD2 | {3'd0, cp[10:6]};
         dec_bytes[1] = PFX_CONT | {2'd0, cp[5:0]};
         dec_last_idx = 2'd1;
      end else if (cp < CP_THREE_END) begin
         dec_bytes[0] = PFX_LEAD3 | {4'd0, cp[15:12]};
         dec_bytes[1] = PFX_CONT | {2'd0, cp[11:6]};
         dec_bytes[2] = PFX_CONT | {2'd0, cp[5:0]};
         dec_last_idx = 2'd2;
      end else begin
         dec_bytes[0] = PFX_LEAD4 | {5'd0, cp[20:18]};
         dec_bytes[1] = PFX_CONT | {2'd0, cp[17:12]};
         dec_bytes[2] = PFX_CONT | {2'd0, cp[11:6]};
         dec_bytes[3] = PFX_CONT | {2'd0, cp[5:0]};
         dec_last_idx = 2'd3;
      end

      // No data: either nothing or a bare token end marker
      dec_has = done;
      dec_any = done || in_data_ff.token_last;
      if (!done) begin
         dec_bytes    = '0;
         dec_last_idx = 2'd0;
      end
   end

   // Result register next state
   always_comb begin
      run_valid_in    = run_valid_ff;
      run_bytes_in    = run_bytes_ff;
      run_last_idx_in = run_last_idx_ff;
      run_idx_in      = run_idx_ff;
      run_has_in      = run_has_ff;
      run_tok_in      = run_tok_ff;
      if (in_move) begin
         run_valid_in    = dec_any;
         run_bytes_in    = dec_bytes;
         run_last_idx_in = dec_last_idx;
         run_idx_in      = 2'd0;
         run_has_in      = dec_has;
         run_tok_in      = in_data_ff.token_last;
      end else if (run_pop) begin
         if (run_idx_ff == run_last_idx_ff) begin
            run_valid_in = 1'b0;
         end else begin
            run_idx_in = run_idx_ff + 2'd1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff    <= 1'b0;
         run_valid_ff  <= 1'b0;
         code_accum_ff <= '0;
         bytes_owed_ff <= 2'd0;
         run_idx_ff    <= 2'd0;
      end else begin
         in_full_ff   <= in_full_in;
         run_valid_ff <= run_valid_in;
         run_idx_ff   <= run_idx_in;
         if (in_move) begin
            code_accum_ff <= code_accum_in;
            bytes_owed_ff <= bytes_owed_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      run_bytes_ff    <= run_bytes_in;
      run_last_idx_ff <= run_last_idx_in;
      run_has_ff      <= run_has_in;
      run_tok_ff      <= run_tok_in;
   end

   // Result port
   assign rsp_valid          = run_valid_ff;
   assign rsp_data.out_byte  = run_bytes_ff[run_idx_ff];
   assign rsp_data.has_byte  = run_has_ff;
   assign rsp_data.run_last  = (run_idx_ff == run_last_idx_ff);
   assign rsp_data.token_end = (run_idx_ff == run_last_idx_ff) && run_tok_ff;

endmodule

// File: rtl/bltd_checker.sv
`timescale 1ns / 1ps
`include "byte_level_token_text_decoder_unit_defines.svh"
module bltd_checker
   import bltd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_held, rsp_held, rsp_end, marker_ok;

   assign req_held  = req_valid && req_stall;
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_end   = rsp_valid && rsp_data.token_end;
   assign marker_ok = (rsp_data.out_byte == 8'h00) && rsp_data.run_last && rsp_data.token_end;

   // A stalled input item stays in place
   `BLTD_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_data))

   // A stalled result item stays in place
   `BLTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // Token end only on the last result of a byte
   `BLTD_ASSERT_IMPLY(a_tok_end_run, clock, reset, rsp_end, rsp_data.run_last)

   // An empty item is always a bare token end marker
   `BLTD_ASSERT_IMPLY(a_empty_marker, clock, reset, rsp_valid && !rsp_data.has_byte, marker_ok)

   // Nothing comes out straight after reset
   `BLTD_ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind byte_level_token_text_decoder_unit bltd_checker u_bltd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
